FILE: src/egsd_pkg.sv
// Package for the Exp-Golomb syntax element decoder: field widths, request,
// prediction mode and status codes, and the CBP mapping tables.
// No dependencies.
package egsd_pkg;

  localparam int WINDOW_BITS = 64;
  localparam int MAX_ZEROS   = 32;

  localparam logic [63:0] WIN_MASK = ~((64'(1) << (64 - WINDOW_BITS)) - 64'(1));

  // Request kinds
  localparam logic [1:0] REQ_UE = 2'd0;
  localparam logic [1:0] REQ_SE = 2'd1;
  localparam logic [1:0] REQ_ME = 2'd2;
  localparam logic [1:0] REQ_TE = 2'd3;

  // Prediction modes
  localparam logic [1:0] MODE_INTRA4X4 = 2'd0;
  localparam logic [1:0] MODE_INTRA8X8 = 2'd1;
  localparam logic [1:0] MODE_INTER    = 2'd2;
  localparam logic [1:0] MODE_OTHER    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ONE   = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_BAD_MODE = 2'd3;

  // Chroma array type codes; mono and 4:4:4 select the short table
  localparam logic [1:0] CAT_MONO = 2'd0;
  localparam logic [1:0] CAT_444  = 2'd3;
  localparam logic [1:0] CAT_RESET = 2'd1;
  localparam logic [1:0] CAT_422  = 2'd2;

  localparam int CBP_A_LEN = 48;
  localparam int CBP_B_LEN = 16;

  typedef logic [5:0] cbp_t;

  localparam cbp_t CBP_A_INTRA [CBP_A_LEN] = '{
    6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
    6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
    6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
    6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
    6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
  };

  localparam cbp_t CBP_A_INTER [CBP_A_LEN] = '{
    6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
    6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
    6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
    6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
    6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
  };

  localparam cbp_t CBP_B_INTRA [CBP_B_LEN] = '{
    6'd15, 6'd0, 6'd7, 6'd11, 6'd13, 6'd14, 6'd3, 6'd5,
    6'd10, 6'd12, 6'd1, 6'd2, 6'd4, 6'd8, 6'd6, 6'd9
  };

  localparam cbp_t CBP_B_INTER [CBP_B_LEN] = '{
    6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd3, 6'd5, 6'd10,
    6'd12, 6'd15, 6'd7, 6'd11, 6'd13, 6'd14, 6'd6, 6'd9
  };

endpackage

FILE: src/exp_golomb_syntax_decoder_core.sv
// Exp-Golomb syntax element decoder core (ue, se, me, te).
// Uses egsd_pkg for codes and the CBP mapping tables.
//
// One element per clock: a transaction is taken whenever start is high and
// busy is low, and its result passes through the input register and the
// result register around a single decode stage (leading-zero encoder, suffix
// shift, mapping and table lookup) before it appears on value, bits_used and
// status with done high for a single cycle. There is no backpressure: the
// receiver must take each result in the cycle it is shown. busy is high only
// while rst is asserted. chroma_array_type resets to 1 and should be written
// only while no transaction is in flight.
module exp_golomb_syntax_decoder_core
  import egsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic [1:0]         req_type,
  input  logic [63:0]        bit_window,
  input  logic [1:0]         pred_mode,
  input  logic [4:0]         te_range,
  output logic               done,
  output logic signed [32:0] value,
  output logic [5:0]         bits_used,
  output logic [1:0]         status
);

  logic [1:0]  chroma_array_type;

  // input register
  logic        in_vld;
  logic [1:0]  in_req;
  logic [63:0] in_win;
  logic [1:0]  in_mode;
  logic [4:0]  in_range;

  // decode stage
  logic [4:0]         zeros;
  logic               found;
  logic [63:0]        shifted;
  logic [31:0]        code_num;
  logic [32:0]        code_inc;
  logic [5:0]         cw_len;
  logic               small_tbl;
  logic [5:0]         cbp;
  logic signed [32:0] value_next;
  logic [5:0]         bits_used_next;
  logic [1:0]         status_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_array_type <= CAT_RESET;
    end else if (cfg_we) begin
      chroma_array_type <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      in_vld <= start && !busy;
      done   <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req   <= req_type;
      in_win   <= bit_window & WIN_MASK;
      in_mode  <= pred_mode;
      in_range <= te_range;
    end
    value     <= value_next;
    bits_used <= bits_used_next;
    status    <= status_next;
  end

  // leading-zero count over the first 32 bits
  always_comb begin
    zeros = '0;
    found = 1'b0;
    for (int i = 0; i < MAX_ZEROS; i++) begin
      if (!found && in_win[63 - i]) begin
        zeros = 5'(i);
        found = 1'b1;
      end
    end
  end

  // codeNum + 1 is the 2L+1 bits that start the window
  always_comb begin
    cw_len   = {zeros, 1'b0} + 6'd1;
    shifted  = in_win >> (6'd63 - {zeros, 1'b0});
    code_num = 32'(({1'b0, shifted[31:0]}) - 33'd1);
    code_inc = {1'b0, code_num} + 33'd1;
  end

  always_comb begin
    small_tbl = (chroma_array_type == CAT_MONO) || (chroma_array_type == CAT_444);
    if (small_tbl) begin
      cbp = (in_mode == MODE_INTER) ? CBP_B_INTER[code_num[3:0]]
                                    : CBP_B_INTRA[code_num[3:0]];
    end else begin
      cbp = (in_mode == MODE_INTER) ? CBP_A_INTER[code_num[5:0]]
                                    : CBP_A_INTRA[code_num[5:0]];
    end
  end

  always_comb begin
    value_next     = '0;
    bits_used_next = '0;
    status_next    = ST_OK;
    if (in_req == REQ_TE && in_range <= 5'd1) begin
      if (in_range == 5'd1) begin
        value_next     = {32'd0, ~in_win[63]};
        bits_used_next = 6'd1;
      end
    end else if (!found) begin
      status_next = ST_NO_ONE;
    end else begin
      bits_used_next = cw_len;
      unique case (in_req)
        REQ_SE: begin
          if (code_num[0]) begin
            value_next = signed'(code_inc >> 1);
          end else begin
            value_next = -signed'({1'b0, code_num} >> 1);
          end
        end
        REQ_ME: begin
          if (in_mode == MODE_OTHER) begin
            status_next = ST_BAD_MODE;
          end else if (small_tbl ? (code_num >= 32'(CBP_B_LEN))
                                 : (code_num >= 32'(CBP_A_LEN))) begin
            status_next = ST_RANGE;
          end else begin
            value_next = {27'd0, cbp};
          end
        end
        default: begin
          // ue, and te with a range above one
          value_next = signed'({1'b0, code_num});
        end
      endcase
    end
  end

endmodule

FILE: src/egsd_checker.sv
// Port-level checker for the Exp-Golomb syntax element decoder core.
// Uses egsd_pkg status codes; bound to exp_golomb_syntax_decoder_core below.
module egsd_checker
  import egsd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [32:0] value,
  input logic [5:0]         bits_used,
  input logic [1:0]         status
);

  // every accepted transaction gives exactly one result on done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a transaction");

  a_no_one: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_NO_ONE) |-> (value == '0 && bits_used == '0))
    else $error("missing terminator result not cleared");

  a_me_error: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_RANGE || status == ST_BAD_MODE))
      |-> (value == '0 && bits_used[0]))
    else $error("table error with nonzero value or even length");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (bits_used[0] || bits_used == '0))
    else $error("codeword length is even");

endmodule

bind exp_golomb_syntax_decoder_core egsd_checker u_egsd_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .value     (value),
  .bits_used (bits_used),
  .status    (status)
);
